// ----- rtl/gbs_pkg.sv -----
// shared types, register codes and helpers for the greedy box suppression block
package gbs_pkg;

    // configuration register codes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IOU_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_KEEP      = 1'b1;

    localparam int THR_W     = 17;
    localparam int KEEP_W    = 9;
    localparam int IOU_SHIFT = 16;

    // one pixel in Q12.4
    localparam logic [4:0] ONE_PIXEL = 5'd16;

    // span arithmetic is done at the widest supported coordinate plus two bits
    localparam int SPAN_CALC_W = 26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_AREA,
        ST_LAUNCH,
        ST_WAIT,
        ST_DONE
    } state_t;

    // overlap verdict handed from slot to slot
    typedef struct packed {
        logic valid;
        logic hit;
    } flag_t;

    // inclusive extent, zero when hi plus one pixel does not exceed lo
    function automatic logic [SPAN_CALC_W-1:0] span_len(
        input logic [SPAN_CALC_W-1:0] lo,
        input logic [SPAN_CALC_W-1:0] hi
    );
        logic [SPAN_CALC_W-1:0] s;
        s = hi + SPAN_CALC_W'(ONE_PIXEL);
        return (s > lo) ? (s - lo) : '0;
    endfunction

endpackage

// ----- rtl/gbs_cell.sv -----
// one slot of the kept-box row: stores a box and tests the passing candidate against it
module gbs_cell #(
    parameter int CW = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [gbs_pkg::THR_W-1:0]            thr,
    input  logic                                 cand_valid,
    input  logic [4*CW+2*(CW+1)-1:0]             cand,
    input  gbs_pkg::flag_t                       flag_in,
    input  logic                                 wr_en,
    input  logic [4*CW+2*(CW+1)-1:0]             wr_box,
    output logic                                 cand_valid_out,
    output logic [4*CW+2*(CW+1)-1:0]             cand_out,
    output gbs_pkg::flag_t                       flag_out
);

    localparam int SW = CW + 1;
    localparam int AW = 2 * SW;
    localparam int BW = 4 * CW + AW;
    localparam int PW = AW + 1 + gbs_pkg::THR_W;
    localparam int CALC = gbs_pkg::SPAN_CALC_W;

    logic [BW-1:0]      box_reg;
    logic               cand_valid_reg;
    logic [BW-1:0]      cand_reg;

    logic [SW-1:0]      w1_reg, h1_reg;
    logic [AW:0]        asum1_reg;
    logic               v1_reg;
    logic [AW-1:0]      inter2_reg;
    logic [AW:0]        asum2_reg;
    logic               v2_reg;
    logic [AW:0]        uni3_reg;
    logic [AW-1:0]      inter3_reg;
    logic               v3_reg;
    logic [PW-1:0]      prod4_reg;
    logic [AW-1:0]      inter4_reg;
    logic               zero4_reg;
    logic               v4_reg;
    gbs_pkg::flag_t     flag_reg;

    logic [CW-1:0]      bx1, by1, bx2, by2, cx1, cy1, cx2, cy2;
    logic [AW-1:0]      barea, carea;
    logic [CW-1:0]      ix1, iy1, ix2, iy2;
    logic [SW-1:0]      w1_next, h1_next;
    logic               hit;

    assign bx1   = box_reg[0*CW +: CW];
    assign by1   = box_reg[1*CW +: CW];
    assign bx2   = box_reg[2*CW +: CW];
    assign by2   = box_reg[3*CW +: CW];
    assign barea = box_reg[4*CW +: AW];
    assign cx1   = cand[0*CW +: CW];
    assign cy1   = cand[1*CW +: CW];
    assign cx2   = cand[2*CW +: CW];
    assign cy2   = cand[3*CW +: CW];
    assign carea = cand[4*CW +: AW];

    // intersection corners
    assign ix1 = (bx1 > cx1) ? bx1 : cx1;
    assign iy1 = (by1 > cy1) ? by1 : cy1;
    assign ix2 = (bx2 < cx2) ? bx2 : cx2;
    assign iy2 = (by2 < cy2) ? by2 : cy2;

    assign w1_next = SW'(gbs_pkg::span_len(CALC'(ix1), CALC'(ix2)));
    assign h1_next = SW'(gbs_pkg::span_len(CALC'(iy1), CALC'(iy2)));

    // empty union only meets a zero threshold
    assign hit = zero4_reg ? (thr == '0)
                           : ((PW'({inter4_reg, {gbs_pkg::IOU_SHIFT{1'b0}}})) >= prod4_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_reg <= wr_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            flag_reg       <= '0;
        end
        else
        begin
            cand_valid_reg <= cand_valid;
            v1_reg         <= cand_valid;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            v4_reg         <= v3_reg;
            flag_reg.valid <= v4_reg;
            flag_reg.hit   <= (flag_in.valid & flag_in.hit) | (v4_reg & hit);
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg   <= cand;
        w1_reg     <= w1_next;
        h1_reg     <= h1_next;
        asum1_reg  <= (AW+1)'(barea) + (AW+1)'(carea);
        inter2_reg <= AW'(w1_reg * h1_reg);
        asum2_reg  <= asum1_reg;
        uni3_reg   <= asum2_reg - (AW+1)'(inter2_reg);
        inter3_reg <= inter2_reg;
        prod4_reg  <= PW'(uni3_reg * thr);
        inter4_reg <= inter3_reg;
        zero4_reg  <= (uni3_reg == '0);
    end

    assign cand_valid_out = cand_valid_reg;
    assign cand_out       = cand_reg;
    assign flag_out       = flag_reg;

endmodule

// ----- rtl/gbs_chain.sv -----
// row of kept-box slots with write decode and verdict selection
module gbs_chain #(
    parameter int N  = 256,
    parameter int CW = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [gbs_pkg::THR_W-1:0]            thr,
    input  logic                                 launch,
    input  logic [4*CW+2*(CW+1)-1:0]             cand,
    input  logic                                 wr_en,
    input  logic [((N > 1) ? $clog2(N) : 1)-1:0] wr_idx,
    input  logic [((N > 1) ? $clog2(N) : 1)-1:0] sel_idx,
    output gbs_pkg::flag_t                       flag_sel
);

    localparam int BW   = 4 * CW + 2 * (CW + 1);
    localparam int IDXW = (N > 1) ? $clog2(N) : 1;

    logic             cv [0:N];
    logic [BW-1:0]    cb [0:N];
    gbs_pkg::flag_t   fl_in  [0:N-1];
    gbs_pkg::flag_t   fl_out [0:N-1];

    assign cv[0]    = launch;
    assign cb[0]    = cand;
    assign fl_in[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_slot
        if (i > 0)
        begin : g_link
            assign fl_in[i] = fl_out[i-1];
        end

        gbs_cell #(
            .CW (CW)
        ) u_slot (
            .clk            (clk),
            .rst_n          (rst_n),
            .thr            (thr),
            .cand_valid     (cv[i]),
            .cand           (cb[i]),
            .flag_in        (fl_in[i]),
            .wr_en          (wr_en && (wr_idx == IDXW'(i))),
            .wr_box         (cand),
            .cand_valid_out (cv[i+1]),
            .cand_out       (cb[i+1]),
            .flag_out       (fl_out[i])
        );
    end

    // verdict is taken at the last occupied slot
    assign flag_sel = fl_out[sel_idx];

endmodule

// ----- rtl/greedy_box_suppression.sv -----
// top level of the greedy box suppression block: control, registers and result stage
//
// channel  direction  transfer on            payload
// s_*      in         s_tvalid & s_tready    tdata index,x1,y1,x2,y2; tlast last_box
// m_*      out        m_tvalid & m_tready    tdata out_index,kept,kept_count; tlast set_done
// cfg_*    in         cfg_we                 cfg_index, cfg_wdata
//
// one candidate is in flight at a time; from transfer it passes the span and area states,
// then straight to its result if the kept list is empty or the keep limit is reached,
// else it walks the slot row one slot a cycle, followed by the five stage overlap test
// in the last occupied slot
// a new candidate is taken while the previous result still waits on m_tready
// reset empties the kept list; stored boxes need no clearing

module greedy_box_suppression #(
    parameter int MAX_KEEP   = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // box_index, box_x1, box_y1, box_x2, box_y2 from the lowest bit up
    input  logic [79:0]                       s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_index, kept, kept_count, zero fill from the lowest bit up
    output logic [31:0]                       m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [gbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gbs_pkg::THR_W-1:0]         cfg_wdata
);

    localparam int CW    = COORD_BITS;
    localparam int IW_IN = (CW < 16) ? CW : 16;
    localparam int SW    = CW + 1;
    localparam int AW    = 2 * SW;
    localparam int BW    = 4 * CW + AW;
    localparam int KCW   = $clog2(MAX_KEEP + 1);
    localparam int IDXW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int LW    = (KCW > gbs_pkg::KEEP_W) ? KCW : gbs_pkg::KEEP_W;
    localparam int CALC  = gbs_pkg::SPAN_CALC_W;

    gbs_pkg::state_t              state_reg, state_next;
    logic [15:0]                  idx_reg;
    logic                         last_reg;
    logic [CW-1:0]                x1_reg, y1_reg, x2_reg, y2_reg;
    logic [SW-1:0]                w_reg, h_reg;
    logic [AW-1:0]                area_reg;
    logic                         keep_reg, keep_next;
    logic [KCW-1:0]               keep_count_reg;
    logic [gbs_pkg::THR_W-1:0]    thr_reg;
    logic [gbs_pkg::KEEP_W-1:0]   max_keep_reg;
    logic                         m_tvalid_reg;
    logic [31:0]                  m_tdata_reg;
    logic                         m_tlast_reg;

    logic                         load;
    logic                         launch;
    logic [LW-1:0]                limit;
    logic                         full;
    logic [KCW-1:0]               count_after;
    logic [KCW-1:0]               count_m1;
    logic [BW-1:0]                cand_bus;
    gbs_pkg::flag_t               flag_sel;

    assign s_tready = (state_reg == gbs_pkg::ST_IDLE);

    assign limit = (LW'(max_keep_reg) < LW'(MAX_KEEP)) ? LW'(max_keep_reg) : LW'(MAX_KEEP);
    assign full  = (LW'(keep_count_reg) >= limit);

    assign count_after = keep_count_reg + KCW'(keep_reg);
    assign count_m1    = keep_count_reg - KCW'(1);
    assign cand_bus    = {area_reg, y2_reg, x2_reg, y1_reg, x1_reg};

    gbs_chain #(
        .N  (MAX_KEEP),
        .CW (CW)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .thr      (thr_reg),
        .launch   (launch),
        .cand     (cand_bus),
        .wr_en    (load && keep_reg),
        .wr_idx   (keep_count_reg[IDXW-1:0]),
        .sel_idx  (count_m1[IDXW-1:0]),
        .flag_sel (flag_sel)
    );

    always_comb
    begin
        state_next = state_reg;
        keep_next  = keep_reg;
        load       = 1'b0;
        launch     = 1'b0;
        case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = gbs_pkg::ST_SPAN;
                end
            end
            gbs_pkg::ST_SPAN:
            begin
                state_next = gbs_pkg::ST_AREA;
            end
            gbs_pkg::ST_AREA:
            begin
                if (full)
                begin
                    keep_next  = 1'b0;
                    state_next = gbs_pkg::ST_DONE;
                end
                else if (keep_count_reg == '0)
                begin
                    keep_next  = 1'b1;
                    state_next = gbs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = gbs_pkg::ST_LAUNCH;
                end
            end
            gbs_pkg::ST_LAUNCH:
            begin
                launch     = 1'b1;
                state_next = gbs_pkg::ST_WAIT;
            end
            gbs_pkg::ST_WAIT:
            begin
                if (flag_sel.valid)
                begin
                    keep_next  = !flag_sel.hit;
                    state_next = gbs_pkg::ST_DONE;
                end
            end
            gbs_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbs_pkg::ST_IDLE;
            keep_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            thr_reg        <= gbs_pkg::THR_W'(45875);
            max_keep_reg   <= gbs_pkg::KEEP_W'(256);
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                keep_count_reg <= last_reg ? '0 : count_after;
            end
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    gbs_pkg::CFG_IOU_THRESHOLD: thr_reg      <= cfg_wdata;
                    gbs_pkg::CFG_MAX_KEEP:      max_keep_reg <= cfg_wdata[gbs_pkg::KEEP_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg <= keep_next;
        if (s_tvalid && s_tready)
        begin
            idx_reg  <= s_tdata[15:0];
            x1_reg   <= CW'(s_tdata[16+IW_IN-1:16]);
            y1_reg   <= CW'(s_tdata[32+IW_IN-1:32]);
            x2_reg   <= CW'(s_tdata[48+IW_IN-1:48]);
            y2_reg   <= CW'(s_tdata[64+IW_IN-1:64]);
            last_reg <= s_tlast;
        end
        w_reg    <= SW'(gbs_pkg::span_len(CALC'(x1_reg), CALC'(x2_reg)));
        h_reg    <= SW'(gbs_pkg::span_len(CALC'(y1_reg), CALC'(y2_reg)));
        area_reg <= AW'(w_reg * h_reg);
        if (load)
        begin
            m_tdata_reg <= {6'b0, gbs_pkg::KEEP_W'(count_after), keep_reg, idx_reg};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        keep_count_reg <= KCW'(MAX_KEEP))
        else $error("kept list longer than the slot row");

    // with an empty list the select wraps to all ones and may see an old verdict
    a_verdict_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_sel.valid && keep_count_reg != '0) |-> state_reg == gbs_pkg::ST_WAIT)
        else $error("slot verdict arrived outside the wait state");

    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        (load && keep_reg && !last_reg) |=>
            keep_count_reg == KCW'($past(keep_count_reg) + 1'b1))
        else $error("kept box not appended");
`endif

endmodule

// ----- dv/greedy_box_suppression_test.sv -----
// self-checking stream testbench for the greedy box suppression block
`timescale 1ns / 100ps

module greedy_box_suppression_test;

    localparam int KEEP_CAP     = 256;
    localparam int BOX_TARGET   = 1150;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICTED    = 1'b0;

    typedef struct packed {
        logic [15:0] x1, y1, x2, y2;
    } corners_t;

    typedef struct packed {
        logic [15:0] index;
        logic        kept;
        logic [8:0]  count;
        logic        done;
    } verdict_t;

    typedef enum logic {
        ROW_BOX,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [gbs_pkg::CFG_INDEX_W-1:0] sel;
        logic [gbs_pkg::THR_W-1:0]       value;
        logic [15:0]                     idx;
        corners_t                        c;
        logic                            last;
        logic                            typed;
        logic                            t_kept;
        logic [8:0]                      t_count;
    } script_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // box_index, box_x1, box_y1, box_x2, box_y2 from the lowest bit up
    logic [79:0]                     s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    // out_index, kept, kept_count, zero fill from the lowest bit up
    logic [31:0]                     m_tdata;
    logic                            m_tlast;
    logic                            cfg_we;
    logic [gbs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gbs_pkg::THR_W-1:0]       cfg_wdata;

    // predictor state
    corners_t                   kept_list [KEEP_CAP];
    int unsigned                kept_num;
    logic [gbs_pkg::THR_W-1:0]  thr_mirror;
    logic [gbs_pkg::KEEP_W-1:0] max_mirror;

    verdict_t    pending_verdicts [$];
    script_row_t script [$];
    int          errors = 0;
    int          boxes_sent = 0;
    int          burst_left = 0;

    greedy_box_suppression dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("greedy_box_suppression regression: fail");
        $finish;
    end

    // inclusive extent in Q12.4, zero when hi plus one pixel does not exceed lo
    function automatic longint extent(longint lo, longint hi);
        longint d;
        d = hi + 16 - lo;
        return (d > 0) ? d : 0;
    endfunction

    function automatic bit overlap_hit(corners_t a, corners_t b);
        longint area_a, area_b, inter, uni;
        longint ix1, iy1, ix2, iy2;
        longint unsigned lhs, rhs;
        area_a = extent(a.x1, a.x2) * extent(a.y1, a.y2);
        area_b = extent(b.x1, b.x2) * extent(b.y1, b.y2);
        ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
        iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
        ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
        iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
        inter = extent(ix1, ix2) * extent(iy1, iy2);
        uni = area_a + area_b - inter;
        // both boxes empty: overlap taken as zero
        if (uni <= 0)
            return thr_mirror == 0;
        lhs = longint'(inter) << gbs_pkg::IOU_SHIFT;
        rhs = longint'(uni) * longint'(thr_mirror);
        return lhs >= rhs;
    endfunction

    function automatic verdict_t judge_candidate(logic [15:0] idx, corners_t c, logic last);
        verdict_t    v;
        int unsigned limit;
        bit          keep;
        limit = (max_mirror < KEEP_CAP) ? max_mirror : KEEP_CAP;
        keep = 1'b0;
        if (kept_num < limit)
        begin
            keep = 1'b1;
            for (int i = 0; i < kept_num; i++)
                if (overlap_hit(kept_list[i], c))
                    keep = 1'b0;
            if (keep)
            begin
                kept_list[kept_num] = c;
                kept_num++;
            end
        end
        v.index = idx;
        v.kept  = keep;
        v.count = kept_num[8:0];
        v.done  = last;
        if (last)
            kept_num = 0;
        return v;
    endfunction

    function automatic script_row_t box_row(logic [15:0] idx, logic [15:0] x1, logic [15:0] y1,
                                            logic [15:0] x2, logic [15:0] y2, logic last,
                                            logic typed, logic k, logic [8:0] n);
        script_row_t r;
        r = '0;
        r.kind    = ROW_BOX;
        r.idx     = idx;
        r.c       = {x1, y1, x2, y2};
        r.last    = last;
        r.typed   = typed;
        r.t_kept  = k;
        r.t_count = n;
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [gbs_pkg::CFG_INDEX_W-1:0] sel,
                                            logic [gbs_pkg::THR_W-1:0] val);
        script_row_t r;
        r = '0;
        r.kind  = ROW_REG;
        r.sel   = sel;
        r.value = val;
        return r;
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    task automatic flag_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // sender in bursts; the expectation is queued at the transfer edge
    task automatic send_box(input logic [15:0] idx, input corners_t c, input logic last,
                            input logic typed, input logic t_kept, input logic [8:0] t_count);
        verdict_t v;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {c.y2, c.x2, c.y1, c.x1, idx};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        v = judge_candidate(idx, c, last);
        if (typed)
        begin
            v.kept  = t_kept;
            v.count = t_count;
        end
        pending_verdicts.push_back(v);
        boxes_sent++;
    endtask

    // registers change only once every queued result has come back
    task automatic write_reg(input logic [gbs_pkg::CFG_INDEX_W-1:0] sel,
                             input logic [gbs_pkg::THR_W-1:0] val);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == gbs_pkg::CFG_IOU_THRESHOLD)
            thr_mirror = val;
        else
            max_mirror = val[gbs_pkg::KEEP_W-1:0];
    endtask

    // clustered candidates so that suppression goes both ways, with some noise boxes
    task automatic run_set(input int len);
        int       ncent, k, jx, jy;
        int       cx [4];
        int       cy [4];
        int       w [4];
        int       h [4];
        corners_t c;
        logic     last;
        ncent = $urandom_range(1, 4);
        for (int j = 0; j < 4; j++)
        begin
            cx[j] = $urandom_range(0, 62000);
            cy[j] = $urandom_range(0, 62000);
            w[j]  = $urandom_range(16, 6000);
            h[j]  = $urandom_range(16, 6000);
        end
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 6) == 0)
                c = {$urandom, $urandom};
            else
            begin
                k  = $urandom_range(0, ncent - 1);
                jx = w[k] / 6 + 1;
                jy = h[k] / 6 + 1;
                c.x1 = clamp16(cx[k] + int'($urandom_range(0, 2 * jx)) - jx);
                c.y1 = clamp16(cy[k] + int'($urandom_range(0, 2 * jy)) - jy);
                c.x2 = clamp16(cx[k] + w[k] + int'($urandom_range(0, 2 * jx)) - jx);
                c.y2 = clamp16(cy[k] + h[k] + int'($urandom_range(0, 2 * jy)) - jy);
            end
            if (i == len - 1)
                last = ($urandom_range(0, 9) != 0);
            else
                last = ($urandom_range(0, 39) == 0);
            send_box(16'($urandom), c, last, PREDICTED, 1'b0, 9'd0);
        end
    endtask

    // receiver stall pattern
    initial
    begin
        int mode, len, n;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            n    = $urandom_range(2, 24);
            for (int i = 0; i < len; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (i >= n);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                flag_field("out_index", want.index, m_tdata[15:0]);
                flag_field("kept", 16'(want.kept), 16'(m_tdata[16]));
                flag_field("kept_count", 16'(want.count), 16'(m_tdata[25:17]));
                flag_field("set_done", 16'(want.done), 16'(m_tlast));
                flag_field("tdata fill", 16'd0, 16'(m_tdata[31:26]));
            end
        end
    end

    initial
    begin
        logic [gbs_pkg::THR_W-1:0]  thr_val;
        logic [gbs_pkg::KEEP_W-1:0] keep_val;
        logic [7:0]                 junk;
        corners_t                   c;
        int                         col, row;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        kept_num   = 0;
        thr_mirror = 17'd45875;
        max_mirror = 9'd256;

        // reset values first: single pixel, corners at the extremes, inverted boxes
        script.push_back(box_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 TYPED, 1'b0, 9'd1));
        script.push_back(box_row(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                                 TYPED, 1'b1, 9'd2));
        script.push_back(box_row(16'h0002, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                                 TYPED, 1'b1, 9'd3));
        // two empty boxes against each other: empty union
        script.push_back(box_row(16'h0003, 16'h8000, 16'h0010, 16'h7FE0, 16'h0000, 1'b1,
                                 TYPED, 1'b1, 9'd4));
        script.push_back(box_row(16'h0004, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h0005, 16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1,
                                 PREDICTED, 1'b0, 9'd0));
        // zero threshold suppresses everything after the first box
        script.push_back(reg_row(gbs_pkg::CFG_IOU_THRESHOLD, 17'd0));
        script.push_back(box_row(16'h0006, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h0007, 16'h8000, 16'h8000, 16'h9000, 16'h9000, 1'b0,
                                 TYPED, 1'b0, 9'd1));
        script.push_back(box_row(16'h0008, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1,
                                 TYPED, 1'b0, 9'd1));
        // threshold of exactly one: only identical boxes are suppressed
        script.push_back(reg_row(gbs_pkg::CFG_IOU_THRESHOLD, 17'd65536));
        script.push_back(box_row(16'h0009, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h000A, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b0,
                                 TYPED, 1'b0, 9'd1));
        script.push_back(box_row(16'h000B, 16'h0010, 16'h0020, 16'h0031, 16'h0040, 1'b1,
                                 TYPED, 1'b1, 9'd2));
        // threshold above one is never met
        script.push_back(reg_row(gbs_pkg::CFG_IOU_THRESHOLD, 17'd65537));
        script.push_back(box_row(16'h000C, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h000D, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b0,
                                 TYPED, 1'b1, 9'd2));
        script.push_back(reg_row(gbs_pkg::CFG_IOU_THRESHOLD, 17'h1FFFF));
        script.push_back(box_row(16'h000E, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 1'b1,
                                 TYPED, 1'b1, 9'd3));
        // keep limits: one, zero (upper data bits set), then lowered mid set
        script.push_back(reg_row(gbs_pkg::CFG_IOU_THRESHOLD, 17'd45875));
        script.push_back(reg_row(gbs_pkg::CFG_MAX_KEEP, 17'd1));
        script.push_back(box_row(16'h000F, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h0010, 16'h5000, 16'h5000, 16'h6000, 16'h6000, 1'b1,
                                 TYPED, 1'b0, 9'd1));
        script.push_back(reg_row(gbs_pkg::CFG_MAX_KEEP, 17'h1FE00));
        script.push_back(box_row(16'h0011, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b1,
                                 TYPED, 1'b0, 9'd0));
        script.push_back(reg_row(gbs_pkg::CFG_MAX_KEEP, 17'd256));
        script.push_back(box_row(16'h0012, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 1'b0,
                                 TYPED, 1'b1, 9'd1));
        script.push_back(box_row(16'h0013, 16'h1000, 16'h1000, 16'h1100, 16'h1100, 1'b0,
                                 TYPED, 1'b1, 9'd2));
        script.push_back(box_row(16'h0014, 16'h2000, 16'h2000, 16'h2100, 16'h2100, 1'b0,
                                 TYPED, 1'b1, 9'd3));
        script.push_back(reg_row(gbs_pkg::CFG_MAX_KEEP, 17'd2));
        script.push_back(box_row(16'h0015, 16'h3000, 16'h3000, 16'h3100, 16'h3100, 1'b1,
                                 TYPED, 1'b0, 9'd3));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
                write_reg(script[i].sel, script[i].value);
            else
                send_box(script[i].idx, script[i].c, script[i].last, script[i].typed,
                         script[i].t_kept, script[i].t_count);
        end

        // fill the whole kept list with disjoint boxes, then run past the limit
        write_reg(gbs_pkg::CFG_IOU_THRESHOLD, 17'($urandom_range(1, 65536)));
        write_reg(gbs_pkg::CFG_MAX_KEEP, 17'd256);
        for (int i = 0; i < 262; i++)
        begin
            col  = i % 16;
            row  = i / 16;
            c.x1 = 16'(col * 4096 + $urandom_range(0, 1000));
            c.x2 = c.x1 + 16'($urandom_range(0, 2500));
            c.y1 = 16'(row * 3840 + $urandom_range(0, 800));
            c.y2 = c.y1 + 16'($urandom_range(0, 2400));
            send_box(16'($urandom), c, (i == 261), PREDICTED, 1'b0, 9'd0);
        end

        while (boxes_sent < BOX_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       thr_val = 17'd0;
                1:       thr_val = 17'd65536;
                2:       thr_val = 17'($urandom_range(65537, 131071));
                3:       thr_val = 17'($urandom_range(0, 131071));
                default: thr_val = 17'($urandom_range(16384, 62000));
            endcase
            case ($urandom_range(0, 9))
                0:       keep_val = 9'd0;
                1:       keep_val = 9'd256;
                2:       keep_val = 9'($urandom_range(257, 511));
                3:       keep_val = 9'($urandom_range(1, 256));
                default: keep_val = 9'($urandom_range(1, 12));
            endcase
            // upper data bits are outside the keep limit register
            junk = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
            write_reg(gbs_pkg::CFG_IOU_THRESHOLD, thr_val);
            write_reg(gbs_pkg::CFG_MAX_KEEP, {junk, keep_val});
            repeat ($urandom_range(2, 5))
                run_set($urandom_range(1, 24));
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("greedy_box_suppression regression: pass");
        else
            $display("greedy_box_suppression regression: fail");
        $finish;
    end

endmodule
